>>> rtl/cbs_pkg.sv
// Shared types, codes and constants of the cubic B-spline evaluator.
// Holds the transfer payloads, controller command and status, and the step table.
// Depends on nothing; every other file but cbs_ram refers to it by scoped names.
package cbs_pkg;

  localparam int MAX_KNOTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MIN_KNOTS     = 5;
  localparam int CTRL_MARGIN   = 4;
  localparam int KNOT_SLOTS    = 6;
  localparam int VAL_SLOTS     = 9;

  localparam logic [6:0] KNOT_COUNT_RESET = 7'd5;

  localparam logic [1:0] OP_LOAD_KNOT = 2'd0;
  localparam logic [1:0] OP_LOAD_CTRL = 2'd1;
  localparam logic [1:0] OP_EVAL      = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  localparam logic [1:0] REGION_INSIDE = 2'd0;
  localparam logic [1:0] REGION_BEFORE = 2'd1;
  localparam logic [1:0] REGION_AFTER  = 2'd2;

  localparam logic [1:0] DERIV1_SCALE = 2'd3;
  localparam logic [1:0] DERIV2_SCALE = 2'd2;
  localparam logic [1:0] DERIV3_SCALE = 2'd1;

  localparam logic [3:0] LAST_FETCH_STEP = 4'd6;
  localparam logic [3:0] LAST_OP_STEP    = 4'd15;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         table_index;
    logic signed [31:0] point_value;
    logic               end_of_batch;
  } req_t;

  typedef struct packed {
    logic signed [31:0] spline_value;
    logic signed [31:0] first_derivative;
    logic signed [31:0] second_derivative;
    logic signed [31:0] third_derivative;
    logic signed [7:0]  segment_index;
    logic [1:0]         region;
    logic               overflow;
    logic signed [31:0] point_echo;
    logic               batch_end;
  } res_t;

  // Value slots: the first nine live in the working RAMs, the rest are result registers.
  typedef enum logic [3:0] {
    SL_P1, SL_P2, SL_P3, SL_P4, SL_Q2, SL_Q3, SL_Q4, SL_R3, SL_R4,
    SL_D3, SL_VAL, SL_D1, SL_D2
  } slot_t;

  typedef enum logic [2:0] {
    KS_TM2, KS_TM1, KS_TM0, KS_TP1, KS_TP2, KS_TP3
  } kslot_t;

  typedef struct packed {
    logic       blend;
    logic [1:0] scale;
    slot_t      hi;
    slot_t      lo;
    kslot_t     ka;
    kslot_t     kb;
    slot_t      dst;
  } op_desc_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_FIRST, S_RD_LAST, S_CHECK, S_END_RD, S_END_WR,
    S_SEARCH, S_SEARCH_CMP, S_FETCH, S_OP_RD, S_OP_SUB, S_OP_MUL,
    S_OP_DIVS, S_OP_DIVW, S_OP_WB, S_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN, D_FIN} div_state_t;

  typedef enum logic [1:0] {KA_FIRST, KA_LAST, KA_MID, KA_FETCH} kaddr_sel_t;
  typedef enum logic {CA_END, CA_FETCH} caddr_sel_t;

  typedef struct packed {
    logic       take;
    kaddr_sel_t kaddr_sel;
    caddr_sel_t caddr_sel;
    logic       hold_first;
    logic       check;
    logic       search_upd;
    logic       fetch_wr;
    logic       end_wr;
    logic       op_sub;
    logic       op_mul;
    logic       div_start;
    logic       op_wb;
    logic       out_load;
    logic [3:0] step;
  } cmd_t;

  typedef struct packed {
    logic       item_eval;
    logic [1:0] region_now;
    logic       search_more;
    logic       div_done;
  } status_t;

  // Derivative steps first, then the blends of value, first and second derivative.
  function automatic op_desc_t op_desc(input logic [3:0] i);
    op_desc_t d;
    case (i)
      4'd0:    d = '{1'b0, DERIV1_SCALE, SL_P4, SL_P3, KS_TM0, KS_TP3, SL_Q4};
      4'd1:    d = '{1'b0, DERIV1_SCALE, SL_P3, SL_P2, KS_TM1, KS_TP2, SL_Q3};
      4'd2:    d = '{1'b0, DERIV1_SCALE, SL_P2, SL_P1, KS_TM2, KS_TP1, SL_Q2};
      4'd3:    d = '{1'b0, DERIV2_SCALE, SL_Q4, SL_Q3, KS_TM0, KS_TP2, SL_R4};
      4'd4:    d = '{1'b0, DERIV2_SCALE, SL_Q3, SL_Q2, KS_TM1, KS_TP1, SL_R3};
      4'd5:    d = '{1'b0, DERIV3_SCALE, SL_R4, SL_R3, KS_TM0, KS_TP1, SL_D3};
      4'd6:    d = '{1'b1, DERIV3_SCALE, SL_P4, SL_P3, KS_TM0, KS_TP3, SL_P4};
      4'd7:    d = '{1'b1, DERIV3_SCALE, SL_P3, SL_P2, KS_TM1, KS_TP2, SL_P3};
      4'd8:    d = '{1'b1, DERIV3_SCALE, SL_P2, SL_P1, KS_TM2, KS_TP1, SL_P2};
      4'd9:    d = '{1'b1, DERIV3_SCALE, SL_P4, SL_P3, KS_TM0, KS_TP2, SL_P4};
      4'd10:   d = '{1'b1, DERIV3_SCALE, SL_P3, SL_P2, KS_TM1, KS_TP1, SL_P3};
      4'd11:   d = '{1'b1, DERIV3_SCALE, SL_P4, SL_P3, KS_TM0, KS_TP1, SL_VAL};
      4'd12:   d = '{1'b1, DERIV3_SCALE, SL_Q4, SL_Q3, KS_TM0, KS_TP2, SL_Q4};
      4'd13:   d = '{1'b1, DERIV3_SCALE, SL_Q3, SL_Q2, KS_TM1, KS_TP1, SL_Q3};
      4'd14:   d = '{1'b1, DERIV3_SCALE, SL_Q4, SL_Q3, KS_TM0, KS_TP1, SL_D1};
      4'd15:   d = '{1'b1, DERIV3_SCALE, SL_R4, SL_R3, KS_TM0, KS_TP1, SL_D2};
      default: d = '{1'b1, DERIV3_SCALE, SL_R4, SL_R3, KS_TM0, KS_TP1, SL_D2};
    endcase
    return d;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic ovf33(input logic signed [32:0] v);
    return v[32] != v[31];
  endfunction

endpackage

>>> rtl/cbs_if.sv
// Valid/ready channel interfaces for request and result transfers.
// Depends on cbs_pkg for the payload types.
interface cbs_req_if;
  logic          valid;
  logic          ready;
  cbs_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cbs_res_if;
  logic          valid;
  logic          ready;
  cbs_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/cbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module cbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/cbs_div.sv
// Iterative signed divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Truncates toward zero, saturates to 32 bits and returns zero for a zero divisor.
// Depends on cbs_pkg for its state type.
module cbs_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo,
  output logic               sat
);

  cbs_pkg::div_state_t state;
  logic [63:0] mag_n;
  logic [31:0] mag_d;
  logic [31:0] rem;
  logic [4:0]  cnt;
  logic        neg;
  logic        zero;
  logic        big;
  logic [32:0] rem_sh;
  logic        qbit;

  always_comb begin
    rem_sh = {rem, mag_n[31]};
    qbit   = rem_sh >= {1'b0, mag_d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbs_pkg::D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        cbs_pkg::D_IDLE: begin
          if (start) begin
            mag_n <= num[63] ? 64'(-num) : 64'(num);
            mag_d <= den[31] ? 32'(-den) : 32'(den);
            neg   <= num[63] ^ den[31];
            zero  <= den == 32'sd0;
            state <= cbs_pkg::D_PREP;
          end
        end
        cbs_pkg::D_PREP: begin
          big   <= mag_n[63:32] >= mag_d;
          rem   <= mag_n[63:32];
          cnt   <= '0;
          state <= (zero || mag_n[63:32] >= mag_d) ? cbs_pkg::D_FIN : cbs_pkg::D_RUN;
        end
        cbs_pkg::D_RUN: begin
          rem   <= qbit ? 32'(rem_sh - {1'b0, mag_d}) : rem_sh[31:0];
          mag_n <= {mag_n[63:32], mag_n[30:0], qbit};
          cnt   <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= cbs_pkg::D_FIN;
          end
        end
        cbs_pkg::D_FIN: begin
          if (zero) begin
            quo <= '0;
            sat <= 1'b0;
          end else if (big) begin
            quo <= neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
            sat <= 1'b1;
          end else if (neg) begin
            quo <= (mag_n[31:0] > 32'h8000_0000) ? 32'sh8000_0000 : 32'(-mag_n[31:0]);
            sat <= mag_n[31:0] > 32'h8000_0000;
          end else begin
            quo <= mag_n[31] ? 32'sh7fff_ffff : mag_n[31:0];
            sat <= mag_n[31];
          end
          done  <= 1'b1;
          state <= cbs_pkg::D_IDLE;
        end
        default: state <= cbs_pkg::D_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/cbs_datapath.sv
// Datapath of the evaluator: table RAMs, search registers, working RAMs,
// subtract, multiply and divide steps, and the result register.
// Depends on cbs_pkg, cbs_ram and cbs_div.
module cbs_datapath #(
  parameter int MAX_KNOTS = cbs_pkg::MAX_KNOTS_DEF,
  parameter int FRAC_BITS = cbs_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_enable,
  input  logic [6:0]             cfg_write_data,
  input  cbs_pkg::req_t          item,
  input  cbs_pkg::cmd_t          cmd,
  output cbs_pkg::status_t       status,
  output cbs_pkg::res_t          res
);

  localparam int CD  = MAX_KNOTS - cbs_pkg::CTRL_MARGIN;
  localparam int AW  = $clog2(MAX_KNOTS);
  localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
  localparam int NW  = $clog2(MAX_KNOTS + 1);
  localparam int IW  = (NW > 6) ? NW : 6;
  localparam int KW  = (NW > 7) ? NW : 7;
  localparam int SW  = NW + 2;

  logic [6:0]         knot_count;
  logic signed [31:0] pv;
  logic               eob;
  logic [NW-1:0]      nknots;
  logic [NW-1:0]      lo;
  logic [NW-1:0]      hi;
  logic [1:0]         region;
  logic signed [31:0] k0;
  logic               ovf;
  logic signed [31:0] weight;
  logic signed [31:0] delta;
  logic signed [31:0] span;
  logic signed [31:0] base;
  logic signed [63:0] num;
  logic signed [31:0] value;
  logic signed [31:0] deriv1;
  logic signed [31:0] deriv2;
  logic signed [31:0] deriv3;

  logic [IW-1:0]      idx_w;
  logic [KW-1:0]      kc_ext;
  logic [NW-1:0]      n_cap;
  logic [NW:0]        mid_sum;
  logic [NW-1:0]      mid;
  logic signed [SW-1:0] k_pos, c_pos, k_lim, c_lim;
  logic [NW-1:0]      k_idx, c_idx;

  logic               k_we, c_we;
  logic [AW-1:0]      k_raddr;
  logic [CAW-1:0]     c_raddr;
  logic [31:0]        k_rdata, c_rdata;
  logic               ks_we;
  logic [2:0]         ks_waddr;
  logic [31:0]        ksa_rdata, ksb_rdata;
  logic               vs_we;
  logic [3:0]         vs_waddr;
  logic [31:0]        vs_wdata;
  logic [31:0]        vsa_rdata, vsb_rdata;
  logic [3:0]         fetch_slot;

  cbs_pkg::op_desc_t  op;
  logic signed [32:0] w33, d33, s33, sum33;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] wb_val;
  logic               div_done;
  logic signed [31:0] quo;
  logic               dsat;

  always_comb begin
    idx_w  = IW'(item.table_index);
    kc_ext = KW'(knot_count);
    if (kc_ext < KW'(cbs_pkg::MIN_KNOTS)) begin
      n_cap = NW'(cbs_pkg::MIN_KNOTS);
    end else if (kc_ext > KW'(MAX_KNOTS)) begin
      n_cap = NW'(MAX_KNOTS);
    end else begin
      n_cap = kc_ext[NW-1:0];
    end
    k_we = cmd.take && item.operation == cbs_pkg::OP_LOAD_KNOT &&
           idx_w < IW'(MAX_KNOTS);
    c_we = cmd.take && item.operation == cbs_pkg::OP_LOAD_CTRL &&
           idx_w < IW'(CD);

    mid_sum = {1'b0, lo} + {1'b0, hi};
    mid     = mid_sum[NW:1];

    k_lim = $signed({2'b00, NW'(nknots - 1'b1)});
    c_lim = $signed({2'b00, NW'(nknots - NW'(cbs_pkg::MIN_KNOTS))});
    k_pos = $signed({2'b00, lo}) + $signed(SW'(cmd.step)) - SW'(2);
    c_pos = $signed({2'b00, lo}) + $signed(SW'(cmd.step)) - SW'(3);
    if (k_pos < 0) begin
      k_idx = '0;
    end else if (k_pos > k_lim) begin
      k_idx = k_lim[NW-1:0];
    end else begin
      k_idx = k_pos[NW-1:0];
    end
    if (c_pos < 0) begin
      c_idx = '0;
    end else if (c_pos > c_lim) begin
      c_idx = c_lim[NW-1:0];
    end else begin
      c_idx = c_pos[NW-1:0];
    end

    case (cmd.kaddr_sel)
      cbs_pkg::KA_FIRST: k_raddr = '0;
      cbs_pkg::KA_LAST:  k_raddr = k_lim[AW-1:0];
      cbs_pkg::KA_MID:   k_raddr = mid[AW-1:0];
      default:           k_raddr = k_idx[AW-1:0];
    endcase
    if (cmd.caddr_sel == cbs_pkg::CA_END) begin
      c_raddr = (region == cbs_pkg::REGION_BEFORE) ? '0 : c_lim[CAW-1:0];
    end else begin
      c_raddr = c_idx[CAW-1:0];
    end

    fetch_slot = cmd.step - 4'd1;
    ks_we      = cmd.fetch_wr && cmd.step != 4'd0 && cmd.step <= cbs_pkg::LAST_FETCH_STEP;
    ks_waddr   = fetch_slot[2:0];

    op = cbs_pkg::op_desc(cmd.step);

    w33 = 33'(pv) - 33'($signed(ksa_rdata));
    d33 = 33'($signed(vsa_rdata)) - 33'($signed(vsb_rdata));
    s33 = 33'($signed(ksb_rdata)) - 33'($signed(ksa_rdata));

    ma   = op.blend ? weight : delta;
    mb   = op.blend ? delta : $signed({30'd0, op.scale});
    prod = ma * mb;

    sum33  = 33'(base) + 33'(quo);
    wb_val = op.blend ? cbs_pkg::sat33(sum33) : quo;

    if (cmd.fetch_wr) begin
      vs_we    = cmd.step != 4'd0 && fetch_slot < 4'(cbs_pkg::CTRL_MARGIN);
      vs_waddr = fetch_slot;
      vs_wdata = c_rdata;
    end else begin
      vs_we    = cmd.op_wb && op.dst < cbs_pkg::SL_D3;
      vs_waddr = op.dst;
      vs_wdata = wb_val;
    end

    status.item_eval   = item.operation == cbs_pkg::OP_EVAL;
    status.search_more = ({1'b0, lo} + 1'b1) < {1'b0, hi};
    status.div_done    = div_done;
    if (pv < k0) begin
      status.region_now = cbs_pkg::REGION_BEFORE;
    end else if (pv >= $signed(k_rdata)) begin
      status.region_now = cbs_pkg::REGION_AFTER;
    end else begin
      status.region_now = cbs_pkg::REGION_INSIDE;
    end
  end

  cbs_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knot_ram (
    .clk(clk), .we(k_we), .waddr(idx_w[AW-1:0]), .wdata(item.point_value),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  cbs_ram #(.WIDTH(32), .DEPTH(CD)) u_ctrl_ram (
    .clk(clk), .we(c_we), .waddr(idx_w[CAW-1:0]), .wdata(item.point_value),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  cbs_ram #(.WIDTH(32), .DEPTH(cbs_pkg::KNOT_SLOTS)) u_kslot_a (
    .clk(clk), .we(ks_we), .waddr(ks_waddr), .wdata(k_rdata),
    .raddr(op.ka), .rdata(ksa_rdata)
  );

  cbs_ram #(.WIDTH(32), .DEPTH(cbs_pkg::KNOT_SLOTS)) u_kslot_b (
    .clk(clk), .we(ks_we), .waddr(ks_waddr), .wdata(k_rdata),
    .raddr(op.kb), .rdata(ksb_rdata)
  );

  cbs_ram #(.WIDTH(32), .DEPTH(cbs_pkg::VAL_SLOTS)) u_vslot_a (
    .clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(vs_wdata),
    .raddr(op.hi), .rdata(vsa_rdata)
  );

  cbs_ram #(.WIDTH(32), .DEPTH(cbs_pkg::VAL_SLOTS)) u_vslot_b (
    .clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(vs_wdata),
    .raddr(op.lo), .rdata(vsb_rdata)
  );

  cbs_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(num), .den(span),
    .done(div_done), .quo(quo), .sat(dsat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count <= cbs_pkg::KNOT_COUNT_RESET;
      region     <= cbs_pkg::REGION_INSIDE;
    end else begin
      if (cfg_write_enable) begin
        knot_count <= cfg_write_data;
      end
      if (cmd.check) begin
        region <= status.region_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pv     <= item.point_value;
      eob    <= item.end_of_batch;
      nknots <= n_cap;
      ovf    <= 1'b0;
    end
    if (cmd.hold_first) begin
      k0 <= $signed(k_rdata);
    end
    if (cmd.check) begin
      lo <= '0;
      hi <= NW'(nknots - 1'b1);
    end
    if (cmd.search_upd) begin
      if (pv < $signed(k_rdata)) begin
        hi <= mid;
      end else begin
        lo <= mid;
      end
    end
    if (cmd.end_wr) begin
      value  <= $signed(c_rdata);
      deriv1 <= '0;
      deriv2 <= '0;
      deriv3 <= '0;
    end
    if (cmd.op_sub) begin
      weight <= cbs_pkg::sat33(w33);
      delta  <= cbs_pkg::sat33(d33);
      span   <= cbs_pkg::sat33(s33);
      base   <= $signed(vsb_rdata);
      ovf    <= ovf | cbs_pkg::ovf33(d33) | cbs_pkg::ovf33(s33) |
                (op.blend & cbs_pkg::ovf33(w33));
    end
    if (cmd.op_mul) begin
      num <= op.blend ? prod : (prod <<< FRAC_BITS);
    end
    if (cmd.op_wb) begin
      ovf <= ovf | dsat | (op.blend & cbs_pkg::ovf33(sum33));
      case (op.dst)
        cbs_pkg::SL_VAL: value  <= wb_val;
        cbs_pkg::SL_D1:  deriv1 <= wb_val;
        cbs_pkg::SL_D2:  deriv2 <= wb_val;
        cbs_pkg::SL_D3:  deriv3 <= wb_val;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      res.spline_value      <= value;
      res.first_derivative  <= deriv1;
      res.second_derivative <= deriv2;
      res.third_derivative  <= deriv3;
      case (region)
        cbs_pkg::REGION_BEFORE: res.segment_index <= -8'sd1;
        cbs_pkg::REGION_AFTER:  res.segment_index <= $signed(8'(nknots));
        default:                res.segment_index <= $signed(8'(lo));
      endcase
      res.region     <= region;
      res.overflow   <= (region == cbs_pkg::REGION_INSIDE) && ovf;
      res.point_echo <= pv;
      res.batch_end  <= eob;
    end
  end

endmodule

>>> rtl/cbs_ctrl.sv
// Controller of the evaluator: sequences bound checks, knot search, operand
// fetch, the sixteen recurrence steps and the result register.
// Depends on cbs_pkg.
module cbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cbs_pkg::status_t  status,
  output cbs_pkg::cmd_t     cmd
);

  cbs_pkg::ctrl_state_t state, state_next;
  logic [3:0]           step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cbs_pkg::S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    step_next     = step;
    cmd           = '0;
    cmd.kaddr_sel = cbs_pkg::KA_FETCH;
    cmd.caddr_sel = cbs_pkg::CA_FETCH;
    cmd.step      = step;
    in_ready      = state == cbs_pkg::S_IDLE;
    cmd.take      = in_valid && in_ready;
    case (state)
      cbs_pkg::S_IDLE: begin
        if (cmd.take && status.item_eval) begin
          state_next = cbs_pkg::S_RD_FIRST;
        end
      end
      cbs_pkg::S_RD_FIRST: begin
        cmd.kaddr_sel = cbs_pkg::KA_FIRST;
        state_next    = cbs_pkg::S_RD_LAST;
      end
      cbs_pkg::S_RD_LAST: begin
        cmd.kaddr_sel  = cbs_pkg::KA_LAST;
        cmd.hold_first = 1'b1;
        state_next     = cbs_pkg::S_CHECK;
      end
      cbs_pkg::S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = (status.region_now == cbs_pkg::REGION_INSIDE) ?
                     cbs_pkg::S_SEARCH : cbs_pkg::S_END_RD;
      end
      cbs_pkg::S_END_RD: begin
        cmd.caddr_sel = cbs_pkg::CA_END;
        state_next    = cbs_pkg::S_END_WR;
      end
      cbs_pkg::S_END_WR: begin
        cmd.end_wr = 1'b1;
        state_next = cbs_pkg::S_DONE;
      end
      cbs_pkg::S_SEARCH: begin
        if (status.search_more) begin
          cmd.kaddr_sel = cbs_pkg::KA_MID;
          state_next    = cbs_pkg::S_SEARCH_CMP;
        end else begin
          step_next  = '0;
          state_next = cbs_pkg::S_FETCH;
        end
      end
      cbs_pkg::S_SEARCH_CMP: begin
        cmd.kaddr_sel  = cbs_pkg::KA_MID;
        cmd.search_upd = 1'b1;
        state_next     = cbs_pkg::S_SEARCH;
      end
      cbs_pkg::S_FETCH: begin
        cmd.fetch_wr = 1'b1;
        if (step == cbs_pkg::LAST_FETCH_STEP) begin
          step_next  = '0;
          state_next = cbs_pkg::S_OP_RD;
        end else begin
          step_next = step + 4'd1;
        end
      end
      cbs_pkg::S_OP_RD: begin
        state_next = cbs_pkg::S_OP_SUB;
      end
      cbs_pkg::S_OP_SUB: begin
        cmd.op_sub = 1'b1;
        state_next = cbs_pkg::S_OP_MUL;
      end
      cbs_pkg::S_OP_MUL: begin
        cmd.op_mul = 1'b1;
        state_next = cbs_pkg::S_OP_DIVS;
      end
      cbs_pkg::S_OP_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = cbs_pkg::S_OP_DIVW;
      end
      cbs_pkg::S_OP_DIVW: begin
        if (status.div_done) begin
          state_next = cbs_pkg::S_OP_WB;
        end
      end
      cbs_pkg::S_OP_WB: begin
        cmd.op_wb = 1'b1;
        if (step == cbs_pkg::LAST_OP_STEP) begin
          state_next = cbs_pkg::S_DONE;
        end else begin
          step_next  = step + 4'd1;
          state_next = cbs_pkg::S_OP_RD;
        end
      end
      cbs_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = cbs_pkg::S_IDLE;
        end
      end
      default: state_next = cbs_pkg::S_IDLE;
    endcase
  end

  a_wb_after_div: assert property (@(posedge clk) disable iff (rst)
    state == cbs_pkg::S_OP_WB |-> $past(state) == cbs_pkg::S_OP_DIVW && $past(status.div_done))
    else $error("write-back entered without a finished division");

  a_fetch_step: assert property (@(posedge clk) disable iff (rst)
    state == cbs_pkg::S_FETCH |-> step <= cbs_pkg::LAST_FETCH_STEP)
    else $error("operand fetch ran past its last step");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == cbs_pkg::S_DONE)
    else $error("result became valid outside the completion state");

endmodule

>>> rtl/cubic_bspline_evaluator.sv
// Cubic B-spline evaluator: top level joining the controller and the datapath.
// Depends on cbs_pkg, cbs_if, cbs_ctrl and cbs_datapath.
//
// Usage: request transfers carry load-knot, load-control-point or evaluate items.
// A load gives no result and leaves the block idle. An evaluate item gives one
// result transfer holding the value, three derivatives, the knot interval, the
// region, an overflow flag and copies of the point and the batch mark.
// Knot count is written through cfg_write_enable/cfg_write_data; the user must
// write it only while idle, as the block itself does not enforce this.
// An evaluation before the first knot or at or after the last reads one end
// control point; inside the range it runs a binary search over the knots, an operand
// fetch, then sixteen recurrence steps, each through the shared bit-serial divider.
// One item is worked on at a time; request ready is high only while idle.
// The result waits in an output register; while it waits, loads and one more
// evaluation are still taken, and a stalled receiver holds that evaluation in its
// final state, with request ready low, until the register is free. Reset clears
// control state and sets the knot count to 5; table contents are undefined until
// loaded.
module cubic_bspline_evaluator #(
  parameter int MAX_KNOTS = cbs_pkg::MAX_KNOTS_DEF,
  parameter int FRAC_BITS = cbs_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_enable,
  input  logic [6:0] cfg_write_data,
  cbs_req_if.sink    request,
  cbs_res_if.source  result
);

  cbs_pkg::cmd_t    cmd;
  cbs_pkg::status_t status;

  cbs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(request.valid), .in_ready(request.ready),
    .out_valid(result.valid), .out_ready(result.ready),
    .status(status), .cmd(cmd)
  );

  cbs_datapath #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
    .item(request.payload), .cmd(cmd), .status(status), .res(result.payload)
  );

endmodule

>>> tb/cbs_checker.sv
// Checker for the cubic B-spline evaluator: watches the request, result and
// knot count ports, predicts each evaluation and compares every result field.
// Depends on cbs_pkg and the channel interfaces in cbs_if.
module cbs_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_enable,
  input  logic [6:0] cfg_write_data,
  cbs_req_if         req,
  cbs_res_if         res,
  output int         pending,
  output int         failures
);

  localparam int KNOT_DEPTH = cbs_pkg::MAX_KNOTS_DEF;
  localparam int CTRL_DEPTH = cbs_pkg::MAX_KNOTS_DEF - cbs_pkg::CTRL_MARGIN;
  localparam longint UNIT = longint'(1) << cbs_pkg::FRAC_BITS_DEF;

  longint knot_tab [KNOT_DEPTH];
  longint ctrl_tab [CTRL_DEPTH];
  logic [6:0] knots_set;
  logic clipped;
  cbs_pkg::res_t awaited [$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint quot(longint num, longint den);
    if (den == 0) return 0;
    return clip32(num / den);
  endfunction

  function automatic longint slope(longint hi, longint lo, longint k, longint a, longint b);
    return quot(clip32(hi - lo) * k * UNIT, clip32(b - a));
  endfunction

  function automatic longint mix(longint t, longint a, longint b, longint p, longint q);
    longint w, d;
    w = clip32(t - a);
    d = clip32(p - q);
    return clip32(q + quot(w * d, clip32(b - a)));
  endfunction

  function automatic longint knot_clamped(int i, int n);
    if (i < 0) i = 0;
    if (i > n - 1) i = n - 1;
    return knot_tab[i];
  endfunction

  function automatic longint ctrl_clamped(int k, int nc);
    if (k < 0) k = 0;
    if (k > nc - 1) k = nc - 1;
    return ctrl_tab[k];
  endfunction

  function automatic cbs_pkg::res_t evaluate(cbs_pkg::req_t r);
    cbs_pkg::res_t e;
    int n, nc, seg, lo, hi, mid;
    longint pv, val, d1, d2, d3, k1, k2, k3;
    longint tm2, tm1, tm0, tp1, tp2, tp3, p1, p2, p3, p4, q2, q3, q4, r3, r4;
    k1 = cbs_pkg::DERIV1_SCALE;
    k2 = cbs_pkg::DERIV2_SCALE;
    k3 = cbs_pkg::DERIV3_SCALE;
    n = knots_set;
    if (n < cbs_pkg::MIN_KNOTS) n = cbs_pkg::MIN_KNOTS;
    if (n > KNOT_DEPTH) n = KNOT_DEPTH;
    nc = n - cbs_pkg::CTRL_MARGIN;
    pv = r.point_value;
    val = 0; d1 = 0; d2 = 0; d3 = 0;
    clipped = 1'b0;
    e.overflow = 1'b0;
    if (pv < knot_tab[0]) begin
      seg = -1;
      e.region = cbs_pkg::REGION_BEFORE;
      val = ctrl_clamped(0, nc);
    end else if (pv >= knot_tab[n - 1]) begin
      seg = n;
      e.region = cbs_pkg::REGION_AFTER;
      val = ctrl_clamped(nc - 1, nc);
    end else begin
      lo = 0;
      hi = n - 1;
      while (lo < hi - 1) begin
        mid = (lo + hi) / 2;
        if (pv < knot_tab[mid]) hi = mid;
        else lo = mid;
      end
      seg = lo;
      e.region = cbs_pkg::REGION_INSIDE;
      tm2 = knot_clamped(seg - 2, n); tm1 = knot_clamped(seg - 1, n);
      tm0 = knot_clamped(seg, n);     tp1 = knot_clamped(seg + 1, n);
      tp2 = knot_clamped(seg + 2, n); tp3 = knot_clamped(seg + 3, n);
      p4 = ctrl_clamped(seg, nc);     p3 = ctrl_clamped(seg - 1, nc);
      p2 = ctrl_clamped(seg - 2, nc); p1 = ctrl_clamped(seg - 3, nc);
      q4 = slope(p4, p3, k1, tm0, tp3);
      q3 = slope(p3, p2, k1, tm1, tp2);
      q2 = slope(p2, p1, k1, tm2, tp1);
      r4 = slope(q4, q3, k2, tm0, tp2);
      r3 = slope(q3, q2, k2, tm1, tp1);
      d3 = slope(r4, r3, k3, tm0, tp1);
      p4 = mix(pv, tm0, tp3, p4, p3);
      p3 = mix(pv, tm1, tp2, p3, p2);
      p2 = mix(pv, tm2, tp1, p2, p1);
      p4 = mix(pv, tm0, tp2, p4, p3);
      p3 = mix(pv, tm1, tp1, p3, p2);
      val = mix(pv, tm0, tp1, p4, p3);
      q4 = mix(pv, tm0, tp2, q4, q3);
      q3 = mix(pv, tm1, tp1, q3, q2);
      d1 = mix(pv, tm0, tp1, q4, q3);
      d2 = mix(pv, tm0, tp1, r4, r3);
      e.overflow = clipped;
    end
    e.spline_value = val[31:0];
    e.first_derivative = d1[31:0];
    e.second_derivative = d2[31:0];
    e.third_derivative = d3[31:0];
    e.segment_index = seg[7:0];
    e.point_echo = r.point_value;
    e.batch_end = r.end_of_batch;
    return e;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    failures++;
  endtask

  initial begin
    failures = 0;
    pending = 0;
    knots_set = cbs_pkg::KNOT_COUNT_RESET;
    foreach (knot_tab[i]) knot_tab[i] = 0;
    foreach (ctrl_tab[i]) ctrl_tab[i] = 0;
  end

  always @(posedge clk) begin
    cbs_pkg::res_t got, want;
    if (rst) begin
      knots_set <= cbs_pkg::KNOT_COUNT_RESET;
    end else begin
      if (cfg_write_enable) knots_set <= cfg_write_data;
      if (req.valid && req.ready) begin
        case (req.payload.operation)
          cbs_pkg::OP_LOAD_KNOT: knot_tab[req.payload.table_index] = req.payload.point_value;
          cbs_pkg::OP_LOAD_CTRL: begin
            if (req.payload.table_index < CTRL_DEPTH)
              ctrl_tab[req.payload.table_index] = req.payload.point_value;
          end
          cbs_pkg::OP_EVAL: awaited.push_back(evaluate(req.payload));
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        got = res.payload;
        if (awaited.size() == 0) begin
          report("unexpected result, point", got.point_echo, 0);
        end else begin
          want = awaited.pop_front();
          if (got.spline_value !== want.spline_value)
            report("spline_value", got.spline_value, want.spline_value);
          if (got.first_derivative !== want.first_derivative)
            report("first_derivative", got.first_derivative, want.first_derivative);
          if (got.second_derivative !== want.second_derivative)
            report("second_derivative", got.second_derivative, want.second_derivative);
          if (got.third_derivative !== want.third_derivative)
            report("third_derivative", got.third_derivative, want.third_derivative);
          if (got.segment_index !== want.segment_index)
            report("segment_index", got.segment_index, want.segment_index);
          if (got.region !== want.region) report("region", got.region, want.region);
          if (got.overflow !== want.overflow) report("overflow", got.overflow, want.overflow);
          if (got.point_echo !== want.point_echo)
            report("point_echo", got.point_echo, want.point_echo);
          if (got.batch_end !== want.batch_end)
            report("batch_end", got.batch_end, want.batch_end);
        end
      end
      pending = awaited.size();
    end
  end

endmodule

>>> tb/tb_cubic_bspline_evaluator.sv
// Testbench top for the cubic B-spline evaluator: clock, reset, knot count
// writes, table loads and evaluation stimulus, result-side stalls and verdict.
// Depends on cbs_pkg, cbs_if, the block and the cbs_checker module.
module tb_cubic_bspline_evaluator;

  localparam int LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write_enable;
  logic [6:0] cfg_write_data;
  int pending, failures, cycles;
  bit stimulus_done, calm;
  longint knot_copy [cbs_pkg::MAX_KNOTS_DEF];
  int knots_live;

  cbs_req_if req_ch ();
  cbs_res_if res_ch ();

  cubic_bspline_evaluator dut (
    .clk(clk), .rst(rst), .cfg_write_enable(cfg_write_enable),
    .cfg_write_data(cfg_write_data), .request(req_ch), .result(res_ch)
  );

  cbs_checker u_checker (
    .clk(clk), .rst(rst), .cfg_write_enable(cfg_write_enable),
    .cfg_write_data(cfg_write_data), .req(req_ch), .res(res_ch),
    .pending(pending), .failures(failures)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, int idx, longint pv, bit eob);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= '{op, idx[5:0], pv[31:0], eob};
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_and_set(int count);
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= count[6:0];
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    knots_live = count < cbs_pkg::MIN_KNOTS ? cbs_pkg::MIN_KNOTS :
                 (count > cbs_pkg::MAX_KNOTS_DEF ? cbs_pkg::MAX_KNOTS_DEF : count);
  endtask

  // Fills both tables; knots ascend with a random spacing, sometimes repeated, and shuffle puts random knots in.
  task automatic fill_tables(int spread, bit shuffle);
    longint k, step, cv;
    k = -(longint'(1) << (spread + 5)) + $urandom_range(0, 1000);
    for (int i = 0; i < cbs_pkg::MAX_KNOTS_DEF; i++) begin
      if (shuffle && $urandom_range(0, 3) == 0) k = $signed($urandom);
      knot_copy[i] = k;
      send(cbs_pkg::OP_LOAD_KNOT, i, k, 1'b0);
      step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << spread);
      k = k + step;
      if (k > 64'sd2147483647) k = 64'sd2147483647;
    end
    for (int i = 0; i < cbs_pkg::MAX_KNOTS_DEF - cbs_pkg::CTRL_MARGIN; i++) begin
      case ($urandom_range(0, 9))
        0: cv = 64'sd2147483647;
        1: cv = -64'sd2147483648;
        2: cv = $signed($urandom);
        default: cv = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      endcase
      send(cbs_pkg::OP_LOAD_CTRL, i, cv, 1'b0);
    end
  endtask

  function automatic longint point_inside();
    longint lo, hi, span;
    lo = knot_copy[0];
    hi = knot_copy[knots_live - 1];
    if (hi <= lo) return lo;
    span = hi - lo + 1;
    return lo + ({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % span;
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      send(cbs_pkg::OP_EVAL, $urandom_range(0, 63), point_inside(), 1'($urandom_range(0, 1)));
    else if (pick < 60)
      send(cbs_pkg::OP_EVAL, $urandom_range(0, 63), $signed($urandom),
           1'($urandom_range(0, 1)));
    else if (pick < 66)
      send(cbs_pkg::OP_EVAL, 0, knot_copy[$urandom_range(0, knots_live - 1)], 1'b1);
    else if (pick < 76)
      send(cbs_pkg::OP_LOAD_KNOT, $urandom_range(0, 63), $signed($urandom), 1'b0);
    else if (pick < 94)
      send(cbs_pkg::OP_LOAD_CTRL, $urandom_range(0, 63), $signed($urandom), 1'b0);
    else
      send(cbs_pkg::OP_UNUSED, $urandom_range(0, 63), $signed($urandom),
           1'($urandom_range(0, 1)));
  endtask

  initial begin
    int counts [6];
    rst = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_write_data = '0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    knots_live = cbs_pkg::MIN_KNOTS;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    calm = 1'b1;
    fill_tables(16, 1'b0);
    calm = 1'b0;
    send(cbs_pkg::OP_EVAL, 0, knot_copy[0] - 1, 1'b0);
    send(cbs_pkg::OP_EVAL, 63, knot_copy[0], 1'b1);
    send(cbs_pkg::OP_EVAL, 0, knot_copy[2], 1'b0);
    send(cbs_pkg::OP_EVAL, 0, knot_copy[4] - 1, 1'b0);
    send(cbs_pkg::OP_EVAL, 0, knot_copy[4], 1'b1);
    send(cbs_pkg::OP_EVAL, 0, 64'sh7fff_ffff, 1'b0);
    send(cbs_pkg::OP_EVAL, 0, -64'sh8000_0000, 1'b1);
    send(cbs_pkg::OP_UNUSED, 63, -1, 1'b1);
    send(cbs_pkg::OP_LOAD_CTRL, 63, 64'sh7fff_ffff, 1'b0);
    send(cbs_pkg::OP_LOAD_CTRL, 0, 64'sh7fff_ffff, 1'b0);
    send(cbs_pkg::OP_LOAD_CTRL, 1, -64'sh8000_0000, 1'b0);
    send(cbs_pkg::OP_LOAD_KNOT, 2, knot_copy[1], 1'b0);
    knot_copy[2] = knot_copy[1];
    send(cbs_pkg::OP_EVAL, 0, knot_copy[1], 1'b0);
    send(cbs_pkg::OP_EVAL, 0, knot_copy[3] - 1, 1'b0);
    send(cbs_pkg::OP_LOAD_KNOT, 3, knot_copy[1] + 1, 1'b0);
    send(cbs_pkg::OP_EVAL, 0, knot_copy[1], 1'b1);

    drain_and_set(cbs_pkg::MAX_KNOTS_DEF);
    counts = '{0, 127, cbs_pkg::MAX_KNOTS_DEF, $urandom_range(5, 64), $urandom_range(0, 127), 5};
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_set(counts[ph]);
      calm = (ph == 2);
      fill_tables($urandom_range(4, 26), ph == 4);
      repeat (180) random_item();
    end
    req_ch.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  initial begin
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    wait (stimulus_done);
    wait (pending == 0);
    repeat (800) @(posedge clk);
    if (failures == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
